[hw/rtl/skbjs_pkg.sv]
// skbjs_pkg: shared constants and types of the skin batch joint splitter.
// Used by every module of the block; depends on nothing.
package skbjs_pkg;

   localparam int JOINT_W        = 16;
   localparam int MAX_JOINTS_DEF = 32;
   localparam int FACE_CAP       = 12;
   localparam int FACE_CNT_W     = 4;
   localparam int LIM_MIN        = 12;
   localparam int CFG_W          = 6;
   localparam int QUEUE_DEPTH    = 2;
   localparam int FACES_W        = 16;

   localparam logic [JOINT_W-1:0] JOINT_NONE = 16'hFFFF;
   localparam logic [CFG_W-1:0]   CFG_RESET  = 6'd32;
   localparam logic [FACES_W-1:0] FACES_MAX  = 16'hFFFF;

   // One vertex word as classified by the front end.
   typedef struct packed {
      logic [3:0][JOINT_W-1:0] joints;
      logic                    face_start;
      logic                    face_end;
      logic                    subset_end;
   } vtx_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

[hw/rtl/skin_batch_joint_splitter_top.sv]
// skin_batch_joint_splitter_top: top level of the skin batch joint splitter.
// Depends on skbjs_pkg, skbjs_front, skbjs_queue and skbjs_back.
//
//  channel | ports                      | direction | moves
//  --------+----------------------------+-----------+------------------------------
//  req     | req_valid/req_stall/fields | in        | one vertex word (4 joints)
//  rsp     | rsp_valid/rsp_stall/fields | out       | one joint word of a group
//  csr     | csr_wr_en/csr_wr_data      | in        | joint limit register
//
// In the back end a vertex word is popped from the queue and its joints are inserted
// one by one into the sorted face chain. The third vertex then checks the face
// joints against the group chain and, when they fit, merges them into it; a closed
// group then emits its joint words one after another.
// Reset clears the control state and the group; cells hold no reset value.
// A stall on rsp holds the output register and, while a group is emitted, the back
// end; the queue lets the front keep taking words until it fills.
module skin_batch_joint_splitter_top import skbjs_pkg::*; #(
   parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CFG_W-1:0]   csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [JOINT_W-1:0] req_joint_a,
   input  logic [JOINT_W-1:0] req_joint_b,
   input  logic [JOINT_W-1:0] req_joint_c,
   input  logic [JOINT_W-1:0] req_joint_d,
   input  logic               req_subset_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [JOINT_W-1:0] rsp_group_joint,
   output logic               rsp_joint_present,
   output logic               rsp_last_of_group,
   output logic [FACES_W-1:0] rsp_group_faces,
   output logic               rsp_closed_by_end
);

   logic [CFG_W-1:0] max_joints_ff;
   q_stat_type       q_stat;
   logic             push, pop;
   vtx_type          push_data, pop_data;

   // Hold the joint limit; write only while idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_joints_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         max_joints_ff <= csr_wr_data;
      end
   end

   // Front: take vertex words, tag face and subset boundaries.
   skbjs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_joint_a     (req_joint_a),
      .req_joint_b     (req_joint_b),
      .req_joint_c     (req_joint_c),
      .req_joint_d     (req_joint_d),
      .req_subset_last (req_subset_last),
      .q_stat          (q_stat),
      .push            (push),
      .push_data       (push_data)
   );

   // Queue: decouple the front from the back.
   skbjs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   // Back: build sets, split groups, emit joint words.
   skbjs_back #(.MAX_JOINTS(MAX_JOINTS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .max_joints        (max_joints_ff),
      .q_stat            (q_stat),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_group_joint   (rsp_group_joint),
      .rsp_joint_present (rsp_joint_present),
      .rsp_last_of_group (rsp_last_of_group),
      .rsp_group_faces   (rsp_group_faces),
      .rsp_closed_by_end (rsp_closed_by_end)
   );

   // An empty group word is always the last of its group.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_joint_present |-> rsp_last_of_group)
      else $error("empty group word not marked last");

   // The queue never takes a word when full nor gives one when empty.
   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full) && !(pop && q_stat.empty))
      else $error("queue overflow or underflow");

   // No result word right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid after reset");

endmodule

[hw/rtl/skbjs_front.sv]
// skbjs_front: accepts vertex words and tags face start, face end and subset end.
// Depends on skbjs_pkg.
module skbjs_front import skbjs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [JOINT_W-1:0] req_joint_a,
   input  logic [JOINT_W-1:0] req_joint_b,
   input  logic [JOINT_W-1:0] req_joint_c,
   input  logic [JOINT_W-1:0] req_joint_d,
   input  logic               req_subset_last,
   input  q_stat_type         q_stat,
   output logic               push,
   output vtx_type            push_data
);

   logic [1:0] phase_ff, phase_in;

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      push_data.joints     = {req_joint_d, req_joint_c, req_joint_b, req_joint_a};
      push_data.face_start = (phase_ff == 2'd0);
      push_data.face_end   = (phase_ff == 2'd2);
      push_data.subset_end = (phase_ff == 2'd2) && req_subset_last;
      phase_in = phase_ff;
      if (push) begin
         phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

[hw/rtl/skbjs_queue.sv]
// skbjs_queue: short queue of classified vertex words between front and back.
// Depends on skbjs_pkg.
module skbjs_queue import skbjs_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  vtx_type    push_data,
   input  logic       pop,
   output vtx_type    pop_data,
   output q_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vtx_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign pop_data     = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/skbjs_back.sv]
// skbjs_back: builds face joint sets, merges them into the group set, emits groups.
// Depends on skbjs_pkg.
module skbjs_back import skbjs_pkg::*; #(
   parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CFG_W-1:0]   max_joints,
   input  q_stat_type         q_stat,
   input  vtx_type            pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [JOINT_W-1:0] rsp_group_joint,
   output logic               rsp_joint_present,
   output logic               rsp_last_of_group,
   output logic [FACES_W-1:0] rsp_group_faces,
   output logic               rsp_closed_by_end
);

   localparam int CNT_W = $clog2(MAX_JOINTS + 1);
   localparam int SUM_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FACE  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_MERGE = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]            state_ff, state_in;
   vtx_type               item_ff, item_in;
   logic [1:0]            jsel_ff, jsel_in;
   logic [FACE_CNT_W-1:0] fidx_ff, fidx_in, fcnt_ff, fcnt_in, newc_ff, newc_in;
   logic [JOINT_W-1:0]    face_ff [FACE_CAP];
   logic [JOINT_W-1:0]    face_in [FACE_CAP];
   logic [JOINT_W-1:0]    grp_ff [MAX_JOINTS];
   logic [JOINT_W-1:0]    grp_in [MAX_JOINTS];
   logic [CNT_W-1:0]      gcnt_ff, gcnt_in, left_ff, left_in;
   logic [FACES_W-1:0]    faces_ff, faces_in;
   logic                  by_end_ff, by_end_in;
   logic                  ov_ff, ov_in;
   logic [JOINT_W-1:0]    oid_ff, oid_in;
   logic                  opres_ff, opres_in, olast_ff, olast_in, oend_ff, oend_in;
   logic [FACES_W-1:0]    ofaces_ff, ofaces_in;

   logic [JOINT_W-1:0]    fv, gv;
   logic [FACE_CAP-1:0]   f_lt, f_eq;
   logic [MAX_JOINTS-1:0] g_lt, g_eq;
   logic                  f_hit, g_hit;
   logic [SUM_W-1:0]      lim, total;
   logic                  out_free;

   assign rsp_valid         = ov_ff;
   assign rsp_group_joint   = oid_ff;
   assign rsp_joint_present = opres_ff;
   assign rsp_last_of_group = olast_ff;
   assign rsp_group_faces   = ofaces_ff;
   assign rsp_closed_by_end = oend_ff;
   assign out_free          = !ov_ff || !rsp_stall;
   assign pop               = (state_ff == ST_IDLE) && !q_stat.empty;

   // Clamp the limit to LIM_MIN..MAX_JOINTS.
   always_comb begin
      lim = SUM_W'(max_joints);
      if (lim < SUM_W'(LIM_MIN)) begin
         lim = SUM_W'(LIM_MIN);
      end else if (lim > SUM_W'(MAX_JOINTS)) begin
         lim = SUM_W'(MAX_JOINTS);
      end
      total = SUM_W'(gcnt_ff) + SUM_W'(newc_ff);
   end

   // Compare cells of both sorted chains against the joint on hand.
   always_comb begin
      fv = item_ff.joints[jsel_ff];
      gv = face_ff[fidx_ff];
      for (int i = 0; i < FACE_CAP; i++) begin
         f_lt[i] = (FACE_CNT_W'(i) < fcnt_ff) && (face_ff[i] < fv);
         f_eq[i] = (FACE_CNT_W'(i) < fcnt_ff) && (face_ff[i] == fv);
      end
      for (int i = 0; i < MAX_JOINTS; i++) begin
         g_lt[i] = (CNT_W'(i) < gcnt_ff) && (grp_ff[i] < gv);
         g_eq[i] = (CNT_W'(i) < gcnt_ff) && (grp_ff[i] == gv);
      end
      f_hit = |f_eq;
      g_hit = |g_eq;
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      jsel_in   = jsel_ff;
      fidx_in   = fidx_ff;
      fcnt_in   = fcnt_ff;
      newc_in   = newc_ff;
      face_in   = face_ff;
      grp_in    = grp_ff;
      gcnt_in   = gcnt_ff;
      left_in   = left_ff;
      faces_in  = faces_ff;
      by_end_in = by_end_ff;
      ov_in     = ov_ff && rsp_stall;
      oid_in    = oid_ff;
      opres_in  = opres_ff;
      olast_in  = olast_ff;
      ofaces_in = ofaces_ff;
      oend_in   = oend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               item_in  = pop_data;
               jsel_in  = 2'd0;
               if (pop_data.face_start) begin
                  fcnt_in = '0;
               end
               state_in = ST_FACE;
            end
         end
         ST_FACE: begin
            // Insert one vertex joint into the face chain.
            if (fv != JOINT_NONE && !f_hit && fcnt_ff < FACE_CNT_W'(FACE_CAP)) begin
               if (!f_lt[0]) begin
                  face_in[0] = fv;
               end
               for (int i = 1; i < FACE_CAP; i++) begin
                  if (!f_lt[i]) begin
                     face_in[i] = f_lt[i-1] ? fv : face_ff[i-1];
                  end
               end
               fcnt_in = fcnt_ff + 1'b1;
            end
            jsel_in = jsel_ff + 2'd1;
            if (jsel_ff == 2'd3) begin
               if (item_ff.face_end) begin
                  fidx_in  = '0;
                  newc_in  = '0;
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CHECK: begin
            // Count face joints missing from the group.
            if (fidx_ff == fcnt_ff) begin
               fidx_in = '0;
               if (total > lim) begin
                  by_end_in = 1'b0;
                  left_in   = gcnt_ff;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ST_MERGE;
               end
            end else begin
               if (!g_hit) begin
                  newc_in = newc_ff + 1'b1;
               end
               fidx_in = fidx_ff + 1'b1;
            end
         end
         ST_MERGE: begin
            if (fidx_ff == fcnt_ff) begin
               if (faces_ff != FACES_MAX) begin
                  faces_in = faces_ff + 1'b1;
               end
               if (item_ff.subset_end) begin
                  by_end_in = 1'b1;
                  left_in   = gcnt_ff;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               if (!g_hit) begin
                  if (!g_lt[0]) begin
                     grp_in[0] = gv;
                  end
                  for (int i = 1; i < MAX_JOINTS; i++) begin
                     if (!g_lt[i]) begin
                        grp_in[i] = g_lt[i-1] ? gv : grp_ff[i-1];
                     end
                  end
                  gcnt_in = gcnt_ff + 1'b1;
               end
               fidx_in = fidx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in     = 1'b1;
               ofaces_in = faces_ff;
               oend_in   = by_end_ff;
               oid_in    = (gcnt_ff == '0) ? '0 : grp_ff[0];
               opres_in  = (gcnt_ff != '0);
               olast_in  = (gcnt_ff == '0) || (left_ff == CNT_W'(1));
               // Advance the chain toward cell zero.
               for (int i = 0; i < MAX_JOINTS - 1; i++) begin
                  grp_in[i] = grp_ff[i+1];
               end
               left_in = left_ff - 1'b1;
               if ((gcnt_ff == '0) || (left_ff == CNT_W'(1))) begin
                  if (by_end_ff) begin
                     gcnt_in  = '0;
                     faces_in = '0;
                     state_in = ST_IDLE;
                  end else begin
                     // Restart the group from the splitting face.
                     for (int i = 0; i < FACE_CAP; i++) begin
                        grp_in[i] = face_ff[i];
                     end
                     gcnt_in  = CNT_W'(fcnt_ff);
                     faces_in = FACES_W'(1);
                     if (item_ff.subset_end) begin
                        by_end_in = 1'b1;
                        left_in   = CNT_W'(fcnt_ff);
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gcnt_ff  <= '0;
         faces_ff <= '0;
         fcnt_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         gcnt_ff  <= gcnt_in;
         faces_ff <= faces_in;
         fcnt_ff  <= fcnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      jsel_ff   <= jsel_in;
      fidx_ff   <= fidx_in;
      newc_ff   <= newc_in;
      face_ff   <= face_in;
      grp_ff    <= grp_in;
      left_ff   <= left_in;
      by_end_ff <= by_end_in;
      oid_ff    <= oid_in;
      opres_ff  <= opres_in;
      olast_ff  <= olast_in;
      ofaces_ff <= ofaces_in;
      oend_ff   <= oend_in;
   end

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for skin_batch_joint_splitter_top.
// Depends on skbjs_pkg and the block's RTL; a clocked driver and monitor check each
// joint word against a predictor of the grouping behavior.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import skbjs_pkg::*;

   localparam int LIMIT_HI   = MAX_JOINTS_DEF;
   localparam int WATCH_MAX  = 20000;
   localparam int DRAIN_WAIT = 400;

   // one vertex word as the driver presents it
   typedef struct packed {
      logic [JOINT_W-1:0] ja, jb, jc, jd;
      logic               last;
   } vert_type;

   // one joint word of a closed group
   typedef struct packed {
      logic [JOINT_W-1:0] jid;
      logic               present;
      logic               last_grp;
      logic [FACES_W-1:0] faces;
      logic               by_end;
   } joint_word_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [CFG_W-1:0] csr_wr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [JOINT_W-1:0] req_joint_a = '0, req_joint_b = '0, req_joint_c = '0, req_joint_d = '0;
   logic req_subset_last = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [JOINT_W-1:0] rsp_group_joint;
   logic rsp_joint_present, rsp_last_of_group, rsp_closed_by_end;
   logic [FACES_W-1:0] rsp_group_faces;

   skin_batch_joint_splitter_top DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_joint_a(req_joint_a), .req_joint_b(req_joint_b),
      .req_joint_c(req_joint_c), .req_joint_d(req_joint_d),
      .req_subset_last(req_subset_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_group_joint(rsp_group_joint), .rsp_joint_present(rsp_joint_present),
      .rsp_last_of_group(rsp_last_of_group), .rsp_group_faces(rsp_group_faces),
      .rsp_closed_by_end(rsp_closed_by_end)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state: a mirror of the group and face chains
   logic [JOINT_W-1:0] grp_set[$];
   logic [JOINT_W-1:0] face_set[$];
   int unsigned        vphase;
   int unsigned        grp_faces;
   logic [CFG_W-1:0]   lim_reg;

   vert_type       pending_verts[$];
   joint_word_type expected_words[$];
   int             n_errors, n_words, n_splits, n_ends;
   bit             stim_done, quiet_idle, hold_send;

   task automatic report_mismatch(input string what);
      n_errors++;
      $display("mismatch @%0t: %s", $realtime, what);
   endtask

   // sorted insert without duplicates, capped at cap entries
   function automatic void put_sorted(ref logic [JOINT_W-1:0] s[$], input logic [JOINT_W-1:0] v,
                                      input int cap);
      int i;
      i = 0;
      while (i < s.size() && s[i] < v) i++;
      if (i < s.size() && s[i] == v) return;
      if (s.size() >= cap) return;
      s.insert(i, v);
   endfunction

   // queue the joint words of the current group
   function automatic void close_group(input logic by_end);
      joint_word_type w;
      w.faces  = grp_faces[FACES_W-1:0];
      w.by_end = by_end;
      if (by_end) n_ends++; else n_splits++;
      if (grp_set.size() == 0) begin
         w.jid = '0; w.present = 1'b0; w.last_grp = 1'b1;
         expected_words.push_back(w);
         return;
      end
      foreach (grp_set[i]) begin
         w.jid = grp_set[i]; w.present = 1'b1; w.last_grp = (i == grp_set.size() - 1);
         expected_words.push_back(w);
      end
   endfunction

   // advance the predictor by one accepted vertex word
   function automatic void predict_vertex(input vert_type v);
      logic [JOINT_W-1:0] merged[$];
      logic [JOINT_W-1:0] js[4];
      int lim;
      js = '{v.ja, v.jb, v.jc, v.jd};
      if (vphase == 0) face_set = {};
      foreach (js[i]) if (js[i] != JOINT_NONE) put_sorted(face_set, js[i], FACE_CAP);
      if (vphase < 2) begin
         vphase++;
         return;
      end
      vphase = 0;
      lim = lim_reg;
      if (lim < LIM_MIN) lim = LIM_MIN;
      if (lim > LIMIT_HI) lim = LIMIT_HI;
      merged = grp_set;
      foreach (face_set[i]) put_sorted(merged, face_set[i], LIMIT_HI + FACE_CAP);
      if (merged.size() > lim) begin
         close_group(1'b0);
         grp_set   = face_set;
         grp_faces = 1;
      end else begin
         grp_set = merged;
         if (grp_faces < 65535) grp_faces++;
      end
      if (v.last) begin
         close_group(1'b1);
         grp_set   = {};
         grp_faces = 0;
      end
   endfunction

   // driver: present the queue head, hold it while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) predict_vertex({req_joint_a, req_joint_b, req_joint_c, req_joint_d,
                                        req_subset_last});
         if (pending_verts.size() > 0 && !hold_send &&
             (quiet_idle || $urandom_range(99) >= 16)) begin
            vert_type v;
            v = pending_verts.pop_front();
            req_valid       <= 1;
            req_joint_a     <= v.ja;
            req_joint_b     <= v.jb;
            req_joint_c     <= v.jc;
            req_joint_d     <= v.jd;
            req_subset_last <= v.last;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor: check accepted joint words, then pick the next stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_words++;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word id=%0d", rsp_group_joint));
            end else begin
               joint_word_type e;
               e = expected_words.pop_front();
               if (rsp_group_joint !== e.jid)
                  report_mismatch($sformatf("group_joint %0d exp %0d", rsp_group_joint, e.jid));
               if (rsp_joint_present !== e.present)
                  report_mismatch($sformatf("joint_present %b exp %b",
                                            rsp_joint_present, e.present));
               if (rsp_last_of_group !== e.last_grp)
                  report_mismatch($sformatf("last_of_group %b exp %b",
                                            rsp_last_of_group, e.last_grp));
               if (rsp_group_faces !== e.faces)
                  report_mismatch($sformatf("group_faces %0d exp %0d",
                                            rsp_group_faces, e.faces));
               if (rsp_closed_by_end !== e.by_end)
                  report_mismatch($sformatf("closed_by_end %b exp %b",
                                            rsp_closed_by_end, e.by_end));
            end
         end
         rsp_stall <= !quiet_idle && ($urandom_range(99) < 16);
      end
   end

   // watchdog: count cycles with no handshake on either channel
   int idle_cycles;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
         $display("watchdog expired, %0d words still expected", expected_words.size());
         $display("** skin_batch_joint_splitter_top: FAILED **");
         $finish;
      end
   end

   function automatic logic [JOINT_W-1:0] rand_joint(input int pool);
      int r;
      r = $urandom_range(99);
      if (r < 10) return JOINT_NONE;
      if (r < 13) return JOINT_W'($urandom());
      return JOINT_W'($urandom_range(pool));
   endfunction

   task automatic add_face(input logic [JOINT_W-1:0] j[12], input logic last);
      for (int i = 0; i < 3; i++)
         pending_verts.push_back({j[4*i], j[4*i+1], j[4*i+2], j[4*i+3], last && i == 2});
   endtask

   task automatic add_rand_face(input int pool, input logic last);
      logic [JOINT_W-1:0] j[12];
      foreach (j[i]) j[i] = rand_joint(pool);
      add_face(j, last);
   endtask

   // wait until the block is idle, then write the joint limit
   task automatic set_limit(input logic [CFG_W-1:0] val);
      wait (pending_verts.size() == 0 && !req_valid && expected_words.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      lim_reg   = val;
   endtask

   initial begin
      logic [JOINT_W-1:0] j[12];
      logic [CFG_W-1:0] lims[6];
      lims = '{6'd0, 6'd12, 6'd63, 6'd20, 6'd13, 6'd32};
      lim_reg = CFG_RESET;
      vphase = 0; grp_faces = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, all-none face, empty group at end, stray subset_last
      foreach (j[i]) j[i] = JOINT_NONE;
      add_face(j, 1'b1);                           // empty group at subset end
      foreach (j[i]) j[i] = JOINT_W'(i);
      add_face(j, 1'b0);
      foreach (j[i]) j[i] = 16'hFFFE - JOINT_W'(i);
      add_face(j, 1'b0);
      foreach (j[i]) j[i] = 16'd100 + JOINT_W'(i);
      add_face(j, 1'b0);                           // 36 joints: forces a split
      pending_verts.push_back({16'd5, 16'd5, 16'd5, 16'd5, 1'b1}); // ignored subset_last
      pending_verts.push_back({16'd0, JOINT_NONE, 16'd0, 16'd1, 1'b0});
      pending_verts.push_back({16'd2, 16'd3, 16'd4, 16'd5, 1'b1});
      set_limit(6'd0);                             // below range, clamps up

      // random phases at several limits; one phase runs without idling
      foreach (lims[p]) begin
         set_limit(lims[p]);
         quiet_idle = (p == 3);
         for (int f = 0; f < 6; f++)
            add_rand_face((p % 2) ? 40 : 300, ($urandom_range(5) == 0) || f == 5);
         if (p == 2) begin
            // hold the sender until the block has caught up
            wait (pending_verts.size() == 0 && !req_valid);
            hold_send = 1;
            wait (expected_words.size() == 0);
            hold_send = 0;
         end
      end
      quiet_idle = 0;
      stim_done  = 1;
      wait (pending_verts.size() == 0 && !req_valid && expected_words.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d joint words: %0d split closes, %0d subset-end closes",
               n_words, n_splits, n_ends);
      if (n_errors == 0 && expected_words.size() == 0)
         $display("** skin_batch_joint_splitter_top: PASSED **");
      else
         $display("** skin_batch_joint_splitter_top: FAILED **");
      $finish;
   end
endmodule

[skin_batch_joint_splitter_top.f]
hw/rtl/skbjs_pkg.sv
hw/rtl/skbjs_front.sv
hw/rtl/skbjs_queue.sv
hw/rtl/skbjs_back.sv
hw/rtl/skin_batch_joint_splitter_top.sv
bench/tb_top.sv
